// File: rtl/edsm_pkg.sv
package edsm_pkg;

  // Table geometry.
  localparam int MAX_DIM         = 256;
  localparam int MAX_STORED_ROWS = 64;

  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ROW_W   = (MAX_STORED_ROWS > 1) ? $clog2(MAX_STORED_ROWS) : 1;
  localparam int SMEM_DEPTH = MAX_STORED_ROWS * MAX_DIM;
  localparam int SADDR_W = (SMEM_DEPTH > 1) ? $clog2(SMEM_DEPTH) : 1;

  // Field widths.
  localparam int TAG_W    = 12;
  localparam int COL_W    = 8;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int SCORE_W  = 40;
  localparam int STORED_W = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_CFG_W  = 9;
  localparam int ROWS_CFG_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B_IN_USE = 1'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

// File: rtl/embedding_dot_similarity_matrix.sv
// Load beats and query beats that do not close a row leave the block idle and ready for the next beat.
// A query beat on the last column starts a run of L2 results; each stored row
// reads D columns through the shared multiply-accumulate unit, then drains
// the pipeline and loads the output register once the output is free.
// Input is stalled for the whole run. Reset sets dim_in_use to 256 and
// rows_b_in_use to 64 and clears control state; the memories are not cleared.
module embedding_dot_similarity_matrix
  import edsm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [TAG_W-1:0]             row_i,
  input  logic [COL_W-1:0]             col_i,
  input  logic signed [VAL_W-1:0]      value_i,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [TAG_W-1:0]             query_row_o,
  output logic [STORED_W-1:0]          stored_row_o,
  output logic signed [SCORE_W-1:0]    score_o,
  output logic                         last_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [DIM_CFG_W-1:0]    dim_q;
  logic [ROWS_CFG_W-1:0]   rows_q;
  logic [DIM_W-1:0]        k_q, k_d;
  logic [ROW_W-1:0]        j_q, j_d;
  logic [TAG_W-1:0]        tag_q;

  logic [DIM_W-1:0]        dim_last;
  logic [ROW_W-1:0]        rows_last;

  logic                    in_fire, load_wr, query_wr, trigger;
  logic                    issue, issue_last;

  logic signed [VAL_W-1:0] smem [SMEM_DEPTH];
  logic signed [VAL_W-1:0] qmem [MAX_DIM];
  logic [SADDR_W-1:0]      s_wr_addr, s_rd_addr;
  logic signed [VAL_W-1:0] s_rd_q, q_rd_q;

  logic                    v1_q, l1_q, v2_q, l2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SCORE_W-1:0] acc_q, acc_d;

  logic                    out_valid_q, out_load;
  logic [STORED_W-1:0]     out_stored_q;
  logic [TAG_W-1:0]        out_tag_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic                    out_last_q;

  // Effective D-1 and L2-1, with zero acting as one and large values clamped.
  always_comb begin
    if (dim_q == '0) begin
      dim_last = '0;
    end else if (int'(dim_q) >= MAX_DIM) begin
      dim_last = DIM_W'(MAX_DIM - 1);
    end else begin
      dim_last = DIM_W'(dim_q - DIM_CFG_W'(1));
    end
    if (rows_q == '0) begin
      rows_last = '0;
    end else if (int'(rows_q) >= MAX_STORED_ROWS) begin
      rows_last = ROW_W'(MAX_STORED_ROWS - 1);
    end else begin
      rows_last = ROW_W'(rows_q - ROWS_CFG_W'(1));
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign load_wr     = in_fire && (req_type_i == REQ_LOAD) && (int'(row_i) < MAX_STORED_ROWS)
                       && (int'(col_i) < MAX_DIM);
  assign query_wr    = in_fire && (req_type_i == REQ_QUERY) && (int'(col_i) < MAX_DIM);
  assign trigger     = in_fire && (req_type_i == REQ_QUERY) && (int'(col_i) == int'(dim_last));

  assign issue      = (state_q == S_ISSUE);
  assign issue_last = issue && (k_q == dim_last);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  assign s_wr_addr = SADDR_W'(row_i) * SADDR_W'(MAX_DIM) + SADDR_W'(col_i);
  assign s_rd_addr = SADDR_W'(j_q) * SADDR_W'(MAX_DIM) + SADDR_W'(k_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    case (state_q)
      S_IDLE: begin
        if (trigger) begin
          state_d = S_ISSUE;
          k_d     = '0;
          j_d     = '0;
        end
      end
      S_ISSUE: begin
        if (issue_last) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + DIM_W'(1);
        end
      end
      S_DRAIN: begin
        if (v2_q && l2_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          k_d = '0;
          if (j_q == rows_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            j_d     = j_q + ROW_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The accumulator is cleared when a stored row starts; the pipeline is empty then.
  always_comb begin
    acc_d = acc_q;
    if (issue && (k_q == '0)) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + SCORE_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      j_q         <= '0;
      dim_q       <= DIM_CFG_W'(256);
      rows_q      <= ROWS_CFG_W'(64);
      v1_q        <= 1'b0;
      l1_q        <= 1'b0;
      v2_q        <= 1'b0;
      l2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      v1_q    <= issue;
      l1_q    <= issue_last;
      v2_q    <= v1_q;
      l2_q    <= l1_q;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DIM_IN_USE:    dim_q  <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_ROWS_B_IN_USE: rows_q <= cfg_data_i[ROWS_CFG_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    if (trigger) begin
      tag_q <= row_i;
    end
    prod_q <= q_rd_q * s_rd_q;
    acc_q  <= acc_d;
    if (out_load) begin
      out_tag_q    <= tag_q;
      out_stored_q <= STORED_W'(j_q);
      out_score_q  <= acc_q;
      out_last_q   <= (j_q == rows_last);
    end
  end

  // Stored matrix: written by load beats, read during a run.
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      smem[s_wr_addr] <= value_i;
    end
    s_rd_q <= smem[s_rd_addr];
  end

  // Query row buffer.
  always_ff @(posedge clk_i) begin
    if (query_wr) begin
      qmem[col_i[DIM_W-1:0]] <= value_i;
    end
    q_rd_q <= qmem[k_q];
  end

  assign out_valid_o  = out_valid_q;
  assign query_row_o  = out_tag_q;
  assign stored_row_o = out_stored_q;
  assign score_o      = out_score_q;
  assign last_o       = out_last_q;

  a_trigger_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trigger |=> (state_q == S_ISSUE) && (k_q == '0) && (j_q == '0))
    else $error("closing query beat did not start a run");

  a_products_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == S_ISSUE) || (state_q == S_DRAIN))
    else $error("product in flight outside a run");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (k_q <= dim_last))
    else $error("column counter past the row length");

  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (j_q <= rows_last))
    else $error("stored row counter past the row count");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result loaded outside the emit step");

endmodule

// File: verif/tb.sv
module tb;
  import edsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RX_HOLD       = 400;
  localparam int ITEM_TARGET   = 140;

  typedef struct {
    logic [TAG_W-1:0]           tag;
    logic [STORED_W-1:0]        stored;
    logic signed [SCORE_W-1:0]  score;
    logic                       last;
  } score_t;

  typedef enum {PLAN_CFG, PLAN_BEAT, PLAN_KNOWN} plan_e;

  // For PLAN_CFG rows, row carries the register index and val the write data.
  typedef struct {
    plan_e                      kind;
    logic                       req;
    logic [TAG_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic [VAL_W-1:0]           val;
    logic signed [SCORE_W-1:0]  score;
  } plan_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_req   = REQ_LOAD;
  logic [TAG_W-1:0]      in_row   = '0;
  logic [COL_W-1:0]      in_col   = '0;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  in_stall_o;

  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DIM_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cfg_ready_o;

  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  logic [TAG_W-1:0]      query_row_o;
  logic [STORED_W-1:0]   stored_row_o;
  logic signed [SCORE_W-1:0] score_o;
  logic                  last_o;

  // Shadow copy of the block's state.
  logic [VAL_W-1:0]      b_table [MAX_STORED_ROWS*MAX_DIM];
  bit                    b_written [MAX_STORED_ROWS*MAX_DIM];
  logic [VAL_W-1:0]      q_buf [MAX_DIM];
  bit                    q_written [MAX_DIM];
  logic [DIM_CFG_W-1:0]  dim_reg  = 9'd256;
  logic [ROWS_CFG_W-1:0] rows_reg = 7'd64;

  score_t scores_due[$];
  int     errors = 0;
  int     beats_done = 0;
  int     hold_requests = 0;
  bit     tx_idle_on = 1'b1;
  bit     rx_idle_on = 1'b1;

  embedding_dot_similarity_matrix dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .req_type_i   (in_req),
    .row_i        (in_row),
    .col_i        (in_col),
    .value_i      (in_value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .query_row_o  (query_row_o),
    .stored_row_o (stored_row_o),
    .score_o      (score_o),
    .last_o       (last_o)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_dim();
    int d;
    d = int'(dim_reg);
    if (d < 1) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  function automatic int eff_rows();
    int r;
    r = int'(rows_reg);
    if (r < 1) r = 1;
    if (r > MAX_STORED_ROWS) r = MAX_STORED_ROWS;
    return r;
  endfunction

  // Updates the shadow state; returns 1 when the beat closes a query row.
  function automatic bit store_beat(logic req, logic [TAG_W-1:0] row, logic [COL_W-1:0] col,
                                    logic [VAL_W-1:0] val);
    int addr;
    if (req == REQ_LOAD) begin
      if (int'(row) < MAX_STORED_ROWS && int'(col) < MAX_DIM) begin
        addr = int'(row) * MAX_DIM + int'(col);
        b_table[addr] = val;
        b_written[addr] = 1'b1;
      end
      return 1'b0;
    end
    if (int'(col) < MAX_DIM) begin
      q_buf[col] = val;
      q_written[col] = 1'b1;
    end
    return int'(col) == eff_dim() - 1;
  endfunction

  function automatic void push_dot_scores(logic [TAG_W-1:0] tag);
    longint acc;
    score_t s;
    int nrows;
    int d;
    nrows = eff_rows();
    d = eff_dim();
    for (int j = 0; j < nrows; j++) begin
      acc = 0;
      for (int k = 0; k < d; k++) begin
        acc += longint'($signed(q_buf[k])) * longint'($signed(b_table[j*MAX_DIM + k]));
      end
      s.tag = tag;
      s.stored = STORED_W'(j);
      s.score = acc[SCORE_W-1:0];
      s.last = (j == nrows - 1);
      scores_due.push_back(s);
    end
  endfunction

  function automatic int idle_len(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic plan_t plan(plan_e kind, logic req, logic [TAG_W-1:0] row,
                                 logic [COL_W-1:0] col, logic [VAL_W-1:0] val,
                                 logic signed [SCORE_W-1:0] score);
    plan_t p;
    p.kind = kind;
    p.req = req;
    p.row = row;
    p.col = col;
    p.val = val;
    p.score = score;
    return p;
  endfunction

  // A known score stands for the single result of a one-row, one-column setup.
  task automatic send_beat(logic req, logic [TAG_W-1:0] row, logic [COL_W-1:0] col,
                           logic [VAL_W-1:0] val, bit known,
                           logic signed [SCORE_W-1:0] known_score);
    int gap;
    score_t s;
    in_valid <= 1'b1;
    in_req   <= req;
    in_row   <= row;
    in_col   <= col;
    in_value <= val;
    @(posedge clk);
    while (in_stall_o !== 1'b0) @(posedge clk);
    if (!(req == REQ_LOAD && int'(row) >= MAX_STORED_ROWS)) beats_done++;
    if (store_beat(req, row, col, val)) begin
      if (known) begin
        s.tag = row;
        s.stored = '0;
        s.score = known_score;
        s.last = 1'b1;
        scores_due.push_back(s);
      end else begin
        push_dot_scores(row);
      end
    end
    gap = idle_len(tx_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    // Let a trailing load beat finish before touching the registers.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == CFG_DIM_IN_USE) dim_reg = data[DIM_CFG_W-1:0];
    else rows_reg = data[ROWS_CFG_W-1:0];
  endtask

  // A dot product may only touch entries that were written, so fill any hole first.
  task automatic fill_unwritten(int d, int nrows);
    for (int j = 0; j < nrows; j++) begin
      for (int k = 0; k < d; k++) begin
        if (!b_written[j*MAX_DIM + k]) begin
          send_beat(REQ_LOAD, TAG_W'(j), COL_W'(k), rand_value(), 1'b0, '0);
        end
      end
    end
    for (int k = 0; k < d - 1; k++) begin
      if (!q_written[k]) begin
        send_beat(REQ_QUERY, TAG_W'($urandom), COL_W'(k), rand_value(), 1'b0, '0);
      end
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] dim_w, logic [CFG_DATA_W-1:0] rows_w,
                           int triggers, bit quiet, bit hold);
    int d;
    int nrows;
    int fired;
    int pick;
    int seq_col;
    logic [TAG_W-1:0] seq_tag;
    logic [COL_W-1:0] col;
    write_reg(CFG_DIM_IN_USE, dim_w);
    write_reg(CFG_ROWS_B_IN_USE, rows_w);
    tx_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    rx_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    if (hold) hold_requests++;
    d = eff_dim();
    nrows = eff_rows();
    fired = 0;
    seq_tag = TAG_W'($urandom);
    seq_col = (d > 16) ? $urandom_range(0, d - 1) : 0;
    while (fired < triggers) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_beat(REQ_LOAD, TAG_W'($urandom_range(0, nrows - 1)),
                  COL_W'($urandom_range(0, d - 1)), rand_value(), 1'b0, '0);
      end else if (pick < 36) begin
        send_beat(REQ_LOAD, TAG_W'($urandom), COL_W'($urandom), rand_value(), 1'b0, '0);
      end else if (pick < 42) begin
        // Stray query element that must not close the row.
        col = COL_W'($urandom);
        if (int'(col) == d - 1) col = col + COL_W'(1);
        send_beat(REQ_QUERY, TAG_W'($urandom), col, rand_value(), 1'b0, '0);
      end else if (pick < 45) begin
        seq_tag = TAG_W'($urandom);
        seq_col = (d > 16) ? $urandom_range(0, d - 1) : 0;
      end else if (seq_col < d - 1) begin
        send_beat(REQ_QUERY, seq_tag, COL_W'(seq_col), rand_value(), 1'b0, '0);
        seq_col++;
      end else begin
        fill_unwritten(d, nrows);
        send_beat(REQ_QUERY, seq_tag, COL_W'(d - 1), rand_value(), 1'b0, '0);
        fired++;
        if (fired > 1 && $urandom_range(0, 3) == 0) wait_drained();
        seq_tag = TAG_W'($urandom);
        seq_col = (d > 16) ? $urandom_range(0, d - 1) : 0;
      end
    end
  endtask

  task automatic check_score();
    score_t e;
    if (scores_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result query_row %0d stored_row %0d score %0d last %0b",
               $time, query_row_o, stored_row_o, score_o, last_o);
      return;
    end
    e = scores_due.pop_front();
    if (query_row_o !== e.tag) begin
      errors++;
      $display("%0t: query_row expected %0d actual %0d", $time, e.tag, query_row_o);
    end
    if (stored_row_o !== e.stored) begin
      errors++;
      $display("%0t: stored_row expected %0d actual %0d", $time, e.stored, stored_row_o);
    end
    if (score_o !== e.score) begin
      errors++;
      $display("%0t: score expected %0d actual %0d", $time, e.score, score_o);
    end
    if (last_o !== e.last) begin
      errors++;
      $display("%0t: last expected %0b actual %0b", $time, e.last, last_o);
    end
  endtask

  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (out_valid_o === 1'b1 && !out_stall) check_score();
      // A requested hold starts once results are flowing, so the block backs up.
      if (holds_served != hold_requests && out_valid_o === 1'b1) begin
        holds_served++;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len(rx_idle_on);
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    plan_t directed_q[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: only loads and query elements that do not close a row.
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd0, 8'd0, 16'h8000, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd64, 8'd0, 16'h7FFF, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd4095, 8'd255, 16'h1234, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd63, 8'd255, 16'h7FFF, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_QUERY, 12'd4095, 8'd0, 16'h8000, '0));
    directed_q.push_back(plan(PLAN_CFG, REQ_LOAD, CFG_DIM_IN_USE, 8'd0, 16'd1, '0));
    directed_q.push_back(plan(PLAN_CFG, REQ_LOAD, CFG_ROWS_B_IN_USE, 8'd0, 16'd1, '0));
    directed_q.push_back(plan(PLAN_KNOWN, REQ_QUERY, 12'd0, 8'd0, 16'h8000,
                              40'sd1073741824));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd0, 8'd0, 16'h7FFF, '0));
    directed_q.push_back(plan(PLAN_KNOWN, REQ_QUERY, 12'd4095, 8'd0, 16'h7FFF,
                              40'sd1073676289));
    directed_q.push_back(plan(PLAN_KNOWN, REQ_QUERY, 12'hABC, 8'd0, 16'h8000,
                              -40'sd1073709056));
    directed_q.push_back(plan(PLAN_BEAT, REQ_QUERY, 12'h555, 8'd5, 16'h1234, '0));
    // Zero in either register acts as one.
    directed_q.push_back(plan(PLAN_CFG, REQ_LOAD, CFG_DIM_IN_USE, 8'd0, 16'd0, '0));
    directed_q.push_back(plan(PLAN_CFG, REQ_LOAD, CFG_ROWS_B_IN_USE, 8'd0, 16'd0, '0));
    directed_q.push_back(plan(PLAN_KNOWN, REQ_QUERY, 12'd1, 8'd0, 16'h0001, 40'sd32767));
    directed_q.push_back(plan(PLAN_KNOWN, REQ_QUERY, 12'd2, 8'd0, 16'h0000, 40'sd0));
    directed_q.push_back(plan(PLAN_CFG, REQ_LOAD, CFG_DIM_IN_USE, 8'd0, 16'd2, '0));
    directed_q.push_back(plan(PLAN_CFG, REQ_LOAD, CFG_ROWS_B_IN_USE, 8'd0, 16'd2, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd0, 8'd1, 16'hFFFF, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd1, 8'd0, 16'h4000, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_LOAD, 12'd1, 8'd1, 16'h8000, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_QUERY, 12'h0F0, 8'd0, 16'h7FFF, '0));
    directed_q.push_back(plan(PLAN_BEAT, REQ_QUERY, 12'h0F0, 8'd1, 16'h8000, '0));

    foreach (directed_q[i]) begin
      if (directed_q[i].kind == PLAN_CFG) begin
        write_reg(directed_q[i].row[CFG_IDX_W-1:0], directed_q[i].val[CFG_DATA_W-1:0]);
      end else begin
        send_beat(directed_q[i].req, directed_q[i].row, directed_q[i].col, directed_q[i].val,
                  directed_q[i].kind == PLAN_KNOWN, directed_q[i].score);
      end
    end

    run_phase(9'd3, 9'd4, 2, 1'b0, 1'b0);
    run_phase(9'd1, 9'd64, 3, 1'b0, 1'b1);
    run_phase(9'd0, 9'd127, 2, 1'b0, 1'b0);
    run_phase(9'd5, 9'd3, 2, 1'b1, 1'b0);
    run_phase(9'd1, 9'd63, 2, 1'b0, 1'b0);
    while (beats_done < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        run_phase(CFG_DATA_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(20, 127)),
                  2, 1'b0, 1'b0);
      end else begin
        run_phase(CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 6)),
                  2, 1'b0, 1'b0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
rtl/edsm_pkg.sv
rtl/embedding_dot_similarity_matrix.sv
verif/tb.sv
